// ----- src/cbm_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbm_pkg
// Shared types and constants for the cross-window binary morphology block.
// ============================================================================
package cbm_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 13;   // input row counter, runs into the tail
    localparam int OROW_W     = 12;   // output row counter
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;

    localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;
    localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;

    localparam logic [FH_W-1:0] H_MIN = 13'd3;
    localparam logic [FH_W-1:0] H_MAX = 13'd4096;
    localparam logic [FW_W-1:0] W_MIN = 11'd3;

    localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MORPH_MODE   = 2'd0,
        REG_APPLY_ENABLE = 2'd1,
        REG_FRAME_WIDTH  = 2'd2,
        REG_FRAME_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic            morph_mode;
        logic            apply_enable;
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic emit;     // this item produces a result
        logic border;   // the result pixel sits on the frame border
        logic last;     // the result pixel is the final one of the frame
    } flags_t;

endpackage

// ----- src/cross_binary_morphology.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cross_binary_morphology
// Streaming 4-neighbour erosion / dilation on 8-bit raster pixels.
// ============================================================================
// The block takes one pixel per clock in raster order and sustains one
// transfer per clock on both sides unless stalled; the figure is set by the
// two line stores, each of which does one write and one registered read per
// cycle. A result passes the window stage and output registers after the
// item that completes its window is taken; that item lies one line plus one
// pixel after the result pixel, so after the last frame pixel send
// frame_width + 1 flush items to drain the frame (a pixel sent in that tail
// is treated as a flush). A flush item sent while frame pixels are still
// due is taken and ignored. Writing frame_width or frame_height restarts
// the frame; configuration is to be written only while the block is idle.
// The line stores are not cleared after reset and need no clearing pass:
// within a frame no result depends on an entry that has not been written.
module cross_binary_morphology #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cbm_pkg::PIX_W-1:0]      pixel_in,
    input  logic                           flush,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cbm_pkg::PIX_W-1:0]      pixel_out,
    output logic                           frame_last,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ------------------------------------------------------------------
    cbm_pkg::cfg_t cfg_reg;
    logic          cfg_wr;
    logic          restart;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && ((cfg_index == cbm_pkg::REG_FRAME_WIDTH) ||
                                  (cfg_index == cbm_pkg::REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.morph_mode   <= cbm_pkg::MODE_ERODE;
            cfg_reg.apply_enable <= 1'b1;
            cfg_reg.frame_width  <= cbm_pkg::WIDTH_RESET;
            cfg_reg.frame_height <= cbm_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                cbm_pkg::REG_MORPH_MODE:   cfg_reg.morph_mode   <= cfg_data[0];
                cbm_pkg::REG_APPLY_ENABLE: cfg_reg.apply_enable <= cfg_data[0];
                cbm_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width  <= cfg_data[cbm_pkg::FW_W-1:0];
                cbm_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[cbm_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The window stage moves on whenever the output register is
    // empty or is being emptied in the same cycle.
    // ------------------------------------------------------------------
    logic                        s1_valid_reg;
    logic [cbm_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [CW-1:0]               s1_col_reg;
    logic [CW-1:0]               s1_lcol_reg;
    cbm_pkg::flags_t             s1_flags_reg;
    logic                        s1_adv;
    logic                        in_take;

    logic                        out_valid_reg;
    logic [cbm_pkg::PIX_W-1:0]   out_pix_reg;
    logic                        out_last_reg;

    assign s1_adv   = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Raster counters: they decide per item whether it enters the window
    // stage, where it reads and writes the line stores, and what result
    // flags it carries.
    // ------------------------------------------------------------------
    logic                        enter;
    logic [cbm_pkg::PIX_W-1:0]   slot_pix;
    logic [CW-1:0]               slot_col;
    logic [CW-1:0]               slot_lcol;
    cbm_pkg::flags_t             slot_flags;

    cbm_scan_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .restart  (restart),
        .step     (in_take),
        .flush    (flush),
        .pixel_in (pixel_in),
        .enter    (enter),
        .pix      (slot_pix),
        .col      (slot_col),
        .lcol     (slot_lcol),
        .flags    (slot_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (enter)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            s1_pix_reg   <= slot_pix;
            s1_col_reg   <= slot_col;
            s1_lcol_reg  <= slot_lcol;
            s1_flags_reg <= slot_flags;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The read is issued as the item is taken and the data
    // arrives with the item in the window stage; the write-back happens as
    // the item leaves that stage.
    // ------------------------------------------------------------------
    logic [cbm_pkg::PIX_W-1:0] up_pix;
    logic [cbm_pkg::PIX_W-1:0] right_pix;
    logic [cbm_pkg::PIX_W-1:0] center_pix;
    logic [cbm_pkg::PIX_W-1:0] result_pix;

    cbm_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_upper (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_adv),
        .wr_addr (s1_lcol_reg),
        .wr_data (center_pix),
        .rd_en   (enter),
        .rd_addr (slot_lcol),
        .rd_data (up_pix)
    );

    cbm_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_middle (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (enter),
        .rd_addr (slot_col),
        .rd_data (right_pix)
    );

    cbm_window_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (s1_adv),
        .cfg    (cfg_reg),
        .border (s1_flags_reg.border),
        .pix    (s1_pix_reg),
        .up     (up_pix),
        .right  (right_pix),
        .res    (result_pix),
        .center (center_pix)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_flags_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_flags_reg.emit)
        begin
            out_pix_reg  <= result_pix;
            out_last_reg <= s1_flags_reg.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_out  = out_pix_reg;
    assign frame_last = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The final pixel of a frame always lies on the border and is emitted.
    a_last_on_border: assert property (@(posedge clk) disable iff (!rst_n)
        (enter && slot_flags.last) |-> (slot_flags.border && slot_flags.emit))
        else $error("frame end flagged off the border or without a result");

    // After the frame end the counters restart, so the next item emits nothing.
    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (enter && slot_flags.last) |=> !slot_flags.emit)
        else $error("raster counters did not restart after the frame end");

    // A full window stage behind a blocked output register holds the input.
    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg && out_valid_reg)
        else $error("window stage or output register lost an item while blocked");

endmodule

// ----- src/cbm_line_buffer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbm_line_buffer
// One line store: one write port, one registered read port, with a bypass
// for a read that hits the address written at the same edge.
// ============================================================================
module cbm_line_buffer #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [cbm_pkg::PIX_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [cbm_pkg::PIX_W-1:0] rd_data
);

    logic [cbm_pkg::PIX_W-1:0] mem [DEPTH];
    logic [cbm_pkg::PIX_W-1:0] rd_reg;
    logic [cbm_pkg::PIX_W-1:0] byp_data_reg;
    logic                      byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg       <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // The array read returns the old word when the same entry is written at
    // the same edge, so the newer word is kept on the side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;

endmodule

// ----- src/cbm_scan_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbm_scan_ctrl
// Input and output raster position counters, geometry clamping, and the
// per-item addressing and result flags.
// ============================================================================
module cbm_scan_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbm_pkg::cfg_t                cfg,
    input  logic                         restart,
    input  logic                         step,
    input  logic                         flush,
    input  logic [cbm_pkg::PIX_W-1:0]    pixel_in,
    output logic                         enter,
    output logic [cbm_pkg::PIX_W-1:0]    pix,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output logic [$clog2(MAX_WIDTH)-1:0] lcol,
    output cbm_pkg::flags_t              flags
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WEW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]                in_col_reg, in_col_next;
    logic [cbm_pkg::ROW_W-1:0]    in_row_reg, in_row_next;
    logic [CW-1:0]                ocol_reg, ocol_next;
    logic [cbm_pkg::OROW_W-1:0]   orow_reg, orow_next;

    logic [WEW-1:0]               w_eff;
    logic [CW-1:0]                w_last;
    logic [cbm_pkg::FH_W-1:0]     h_eff;
    logic [cbm_pkg::FH_W-1:0]     h_last;
    logic                         in_frame;
    logic                         col_wrap;
    logic                         ocol_wrap;

    always_comb
    begin
        if (cfg.frame_width < cbm_pkg::W_MIN)
        begin
            w_eff = WEW'(cbm_pkg::W_MIN);
        end
        else if (32'(cfg.frame_width) > MAX_WIDTH)
        begin
            w_eff = WEW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WEW'(cfg.frame_width);
        end

        if (cfg.frame_height < cbm_pkg::H_MIN)
        begin
            h_eff = cbm_pkg::H_MIN;
        end
        else if (cfg.frame_height > cbm_pkg::H_MAX)
        begin
            h_eff = cbm_pkg::H_MAX;
        end
        else
        begin
            h_eff = cbm_pkg::FH_W'(cfg.frame_height);
        end
    end

    assign w_last = CW'(w_eff - WEW'(1));
    assign h_last = h_eff - cbm_pkg::FH_W'(1);

    // The column counter never reaches the width, so the row alone tells
    // whether frame pixels are still due.
    assign in_frame = in_row_reg < h_eff;
    assign enter    = step && !(flush && in_frame);
    assign pix      = in_frame ? pixel_in : cbm_pkg::PIX_LOW;
    assign col      = in_col_reg;
    assign lcol     = (in_col_reg == '0) ? w_last : in_col_reg - CW'(1);

    assign flags.emit   = (in_row_reg >= cbm_pkg::ROW_W'(2)) ||
                          ((in_row_reg == cbm_pkg::ROW_W'(1)) && (in_col_reg != '0));
    assign flags.border = (orow_reg == '0) || ({1'b0, orow_reg} >= h_last) ||
                          (ocol_reg == '0) || (ocol_reg == w_last);
    assign flags.last   = ({1'b0, orow_reg} == h_last) && (ocol_reg == w_last);

    assign col_wrap  = in_col_reg == w_last;
    assign ocol_wrap = ocol_reg == w_last;

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (restart)
        begin
            in_col_next = '0;
            in_row_next = '0;
            ocol_next   = '0;
            orow_next   = '0;
        end
        else if (enter)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + cbm_pkg::ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (flags.emit)
            begin
                if (flags.last)
                begin
                    in_col_next = '0;
                    in_row_next = '0;
                    ocol_next   = '0;
                    orow_next   = '0;
                end
                else if (ocol_wrap)
                begin
                    ocol_next = '0;
                    orow_next = orow_reg + cbm_pkg::OROW_W'(1);
                end
                else
                begin
                    ocol_next = ocol_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

endmodule

// ----- src/cbm_window_alu.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cbm_window_alu
// Window taps for the current line and the erode / dilate decision on the
// cross-shaped neighbourhood.
// ============================================================================
module cbm_window_alu (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  cbm_pkg::cfg_t             cfg,
    input  logic                      border,
    input  logic [cbm_pkg::PIX_W-1:0] pix,
    input  logic [cbm_pkg::PIX_W-1:0] up,
    input  logic [cbm_pkg::PIX_W-1:0] right,
    output logic [cbm_pkg::PIX_W-1:0] res,
    output logic [cbm_pkg::PIX_W-1:0] center
);

    logic [cbm_pkg::PIX_W-1:0] tap0_reg;
    logic [cbm_pkg::PIX_W-1:0] tap1_reg;
    logic [cbm_pkg::PIX_W-1:0] tap2_reg;
    logic [cbm_pkg::PIX_W-1:0] down;
    logic [cbm_pkg::PIX_W-1:0] left;
    logic                      any_low;
    logic                      any_high;

    assign down   = tap0_reg;
    assign center = tap1_reg;
    assign left   = tap2_reg;

    assign any_low  = (up == cbm_pkg::PIX_LOW) || (down == cbm_pkg::PIX_LOW) ||
                      (left == cbm_pkg::PIX_LOW) || (right == cbm_pkg::PIX_LOW);
    assign any_high = (up == cbm_pkg::PIX_HIGH) || (down == cbm_pkg::PIX_HIGH) ||
                      (left == cbm_pkg::PIX_HIGH) || (right == cbm_pkg::PIX_HIGH);

    always_comb
    begin
        if (!cfg.apply_enable)
        begin
            res = center;
        end
        else if (cfg.morph_mode == cbm_pkg::MODE_ERODE)
        begin
            res = (!border && any_low) ? cbm_pkg::PIX_LOW : center;
        end
        else if (border)
        begin
            res = cbm_pkg::PIX_LOW;
        end
        else
        begin
            res = any_high ? cbm_pkg::PIX_HIGH : center;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap0_reg <= '0;
            tap1_reg <= '0;
            tap2_reg <= '0;
        end
        else if (adv)
        begin
            tap2_reg <= tap1_reg;
            tap1_reg <= right;
            tap0_reg <= pix;
        end
    end

endmodule

// ----- tb/cross_binary_morphology_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// cross_binary_morphology_test
// Self-checking bench for the cross-window erosion / dilation block.
// ============================================================================
// A queue of pixel and flush transfers feeds a driver that changes the
// inputs on the falling edge. A monitor samples every handshake on the
// rising edge. Each accepted input transfer runs through a predictor that
// mirrors the block's line stores, window taps and frame counters, and any
// pixel it produces is queued as an expected result. Each accepted output
// transfer is checked field by field against the oldest expected pixel.
// The run starts with two hand-built 3x3 frames. A partial frame at an
// out-of-range geometry, which clamps to the largest legal one, follows.
// Then come randomized settings under four idling patterns, and finally a
// long receiver hold-off that backs the block up into its input.
// ============================================================================
module cross_binary_morphology_test;

    localparam int MAX_W       = 1024;
    localparam int SETTLE      = 10;       // a result passes the window stage and output register after its item
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 500000;

    typedef struct packed {
        logic [cbm_pkg::PIX_W-1:0] pix;
        logic                      is_flush;
    } pixel_item_t;

    typedef struct packed {
        logic [cbm_pkg::PIX_W-1:0] pix;
        logic                      frame_end;
    } morph_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [cbm_pkg::PIX_W-1:0]      pixel_in = '0;
    logic                           flush = 1'b0;

    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [cbm_pkg::PIX_W-1:0]      pixel_out;
    logic                           frame_last;

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    cbm_pkg::cfg_reg_t              cfg_index = cbm_pkg::REG_MORPH_MODE;
    logic [cbm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus and checking state.
    pixel_item_t   pixels_to_send [$];
    morph_result_t expected_pixels [$];
    int            items_queued = 0;
    int            mismatches = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          item_taken = 1'b0;
    logic          hold_request = 1'b0;
    logic          hold_off = 1'b0;
    int            cycles;

    // Predictor copy of the configuration and of the block's storage.
    logic                      mode_q;
    logic                      apply_q;
    logic [cbm_pkg::FW_W-1:0]  width_q;
    logic [cbm_pkg::FH_W-1:0]  height_q;
    logic [cbm_pkg::PIX_W-1:0] upper_store [MAX_W];
    logic [cbm_pkg::PIX_W-1:0] middle_store [MAX_W];
    logic [cbm_pkg::PIX_W-1:0] tap_newest;
    logic [cbm_pkg::PIX_W-1:0] tap_middle;
    logic [cbm_pkg::PIX_W-1:0] tap_oldest;
    int unsigned               in_col_q;
    int unsigned               in_row_q;
    int unsigned               out_idx_q;

    cross_binary_morphology #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel_in(pixel_in),
        .flush(flush),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pixel_out(pixel_out),
        .frame_last(frame_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void restart_frame();
        in_col_q  = 0;
        in_row_q  = 0;
        out_idx_q = 0;
    endfunction

    // Advances the predicted block by one accepted input transfer and queues
    // the pixel that it releases, if any. The released pixel sits one line
    // and one pixel behind the newest input.
    function automatic void predict_morph(input logic [cbm_pkg::PIX_W-1:0] pix,
                                          input logic is_flush);
        int unsigned               w, h, total, pos, c, lc, orow, ocol;
        logic [cbm_pkg::PIX_W-1:0] v, up, down, left, right, center, res;
        logic                      emit, border, at_end, any_low, any_high;
        morph_result_t             r;
        w = (width_q < cbm_pkg::W_MIN) ? cbm_pkg::W_MIN :
            ((width_q > MAX_W) ? MAX_W : width_q);
        h = (height_q < cbm_pkg::H_MIN) ? cbm_pkg::H_MIN :
            ((height_q > cbm_pkg::H_MAX) ? cbm_pkg::H_MAX : height_q);
        total = w * h;
        pos = in_row_q * w + in_col_q;

        // A flush while frame pixels are still due changes nothing.
        if (is_flush && pos < total)
            return;
        // Anything in the tail pads with zero, whatever it carries.
        v = (pos < total) ? pix : cbm_pkg::PIX_LOW;

        c  = (in_col_q < w) ? in_col_q : 0;
        lc = (c == 0) ? w - 1 : c - 1;
        right  = middle_store[c];
        up     = upper_store[lc];
        down   = tap_newest;
        center = tap_middle;
        left   = tap_oldest;
        upper_store[lc] = center;
        middle_store[c] = v;
        tap_oldest = center;
        tap_middle = right;
        tap_newest = v;

        emit = (in_row_q >= 2) || (in_row_q == 1 && in_col_q >= 1);
        in_col_q++;
        if (in_col_q >= w)
        begin
            in_col_q = 0;
            in_row_q++;
        end
        if (!emit)
            return;

        orow = out_idx_q / w;
        ocol = out_idx_q % w;
        border = (orow == 0) || (orow >= h - 1) || (ocol == 0) || (ocol == w - 1);
        any_low  = (up == cbm_pkg::PIX_LOW) || (down == cbm_pkg::PIX_LOW) ||
                   (left == cbm_pkg::PIX_LOW) || (right == cbm_pkg::PIX_LOW);
        any_high = (up == cbm_pkg::PIX_HIGH) || (down == cbm_pkg::PIX_HIGH) ||
                   (left == cbm_pkg::PIX_HIGH) || (right == cbm_pkg::PIX_HIGH);
        if (!apply_q)
            res = center;
        else if (mode_q == cbm_pkg::MODE_ERODE)
            res = (!border && any_low) ? cbm_pkg::PIX_LOW : center;
        else if (border)
            res = cbm_pkg::PIX_LOW;
        else if (any_high)
            res = cbm_pkg::PIX_HIGH;
        else
            res = center;

        at_end = (out_idx_q >= total - 1);
        if (at_end)
            restart_frame();
        else
            out_idx_q++;

        r.pix = res;
        r.frame_end = at_end;
        expected_pixels.insert(expected_pixels.size(), r);
    endfunction

    function automatic void report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d at %0t ns", what, want, got, $time);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: all handshakes are sampled on the rising edge. Results are
    // checked before the input of the same edge is predicted; the block
    // cannot return a pixel in the cycle that completes its window anyway.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        morph_result_t want;
        int k;
        if (!rst_n)
        begin
            mode_q   = cbm_pkg::MODE_ERODE;
            apply_q  = 1'b1;
            width_q  = cbm_pkg::WIDTH_RESET;
            height_q = cbm_pkg::HEIGHT_RESET;
            for (k = 0; k < MAX_W; k++)
            begin
                upper_store[k]  = cbm_pkg::PIX_LOW;
                middle_store[k] = cbm_pkg::PIX_LOW;
            end
            tap_newest = cbm_pkg::PIX_LOW;
            tap_middle = cbm_pkg::PIX_LOW;
            tap_oldest = cbm_pkg::PIX_LOW;
            restart_frame();
            item_taken <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("pixel_out with nothing expected", -1, pixel_out);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want.pix)
                        report_mismatch("pixel_out", want.pix, pixel_out);
                    if (frame_last !== want.frame_end)
                        report_mismatch("frame_last", want.frame_end, frame_last);
                end
            end

            // Width and height writes restart the frame, as in the block.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cbm_pkg::REG_MORPH_MODE:   mode_q  = cfg_data[0];
                    cbm_pkg::REG_APPLY_ENABLE: apply_q = cfg_data[0];
                    cbm_pkg::REG_FRAME_WIDTH:
                    begin
                        width_q = cfg_data[cbm_pkg::FW_W-1:0];
                        restart_frame();
                    end
                    cbm_pkg::REG_FRAME_HEIGHT:
                    begin
                        height_q = cfg_data[cbm_pkg::FH_W-1:0];
                        restart_frame();
                    end
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                predict_morph(pixel_in, flush);
            item_taken <= in_valid && !in_stall;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: a new input transfer is offered only once the previous one has
    // been taken, so a stalled payload holds. The random idle roll never
    // looks at in_stall.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        pixel_item_t nxt;
        if (!in_valid || item_taken)
        begin
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pixels_to_send.pop_front();
                in_valid <= 1'b1;
                pixel_in <= nxt.pix;
                flush    <= nxt.is_flush;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    // The long receiver hold-off is timed here, apart from the stimulus, so
    // the sender keeps offering transfers while the output is blocked.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_request);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // A run that does not finish in time has lost a result or hung.
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_item(input logic [cbm_pkg::PIX_W-1:0] pix,
                                       input logic is_flush);
        pixel_item_t it;
        it.pix = pix;
        it.is_flush = is_flush;
        pixels_to_send.insert(pixels_to_send.size(), it);
        items_queued++;
    endfunction

    // Mostly binary pixels, where the morphology matters, with a share of
    // arbitrary gray values that must be kept or cleared as they are.
    function automatic logic [cbm_pkg::PIX_W-1:0] random_pixel(input int density);
        if ($urandom_range(3) == 0)
            return cbm_pkg::PIX_W'($urandom_range(255));
        return ($urandom_range(99) < density) ? cbm_pkg::PIX_HIGH : cbm_pkg::PIX_LOW;
    endfunction

    // Queues one frame and its tail of w + 1 padding transfers. A cut frame
    // stops early and leaves the block mid-frame until the next geometry
    // write. Stray flushes inside the frame and pixels in the tail are noise
    // that the block has to discard.
    function automatic void queue_frame(input int w, input int h, input bit cut);
        int total, cut_at, k, density;
        pixel_item_t stray;
        total = w * h;
        density = $urandom_range(95, 5);
        cut_at = cut ? $urandom_range(total + w, 1) : total + w + 1;
        stray.is_flush = 1'b1;
        for (k = 0; k < cut_at; k++)
        begin
            if (k < total)
            begin
                if ($urandom_range(19) == 0)
                begin
                    stray.pix = cbm_pkg::PIX_W'($urandom_range(255));
                    pixels_to_send.insert(pixels_to_send.size(), stray);
                end
                queue_item(random_pixel(density), 1'b0);
            end
            else
                queue_item(cbm_pkg::PIX_W'($urandom_range(255)), $urandom_range(5) != 0);
        end
        // A flush right after a finished frame falls into the next frame.
        if (!cut && $urandom_range(7) == 0)
        begin
            stray.pix = cbm_pkg::PIX_W'($urandom_range(255));
            pixels_to_send.insert(pixels_to_send.size(), stray);
        end
    endfunction

    task automatic write_reg(input cbm_pkg::cfg_reg_t idx,
                             input logic [cbm_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued transfer is taken and every expected pixel
    // has come back, then lets the pipeline empty of items that produce no
    // result.
    task automatic wait_for_idle();
        @(posedge clk);
        while (pixels_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Picks a random configuration, including widths and heights below the
    // legal minimum, and queues one to three frames under it. Unused data
    // bits of the narrow registers carry random values.
    task automatic run_random_setting();
        int raw_w, raw_h, w, h, frames, f;
        logic [cbm_pkg::CFG_DATA_W-1:0] data;
        raw_w = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
        raw_h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
        w = (raw_w < cbm_pkg::W_MIN) ? cbm_pkg::W_MIN : raw_w;
        h = (raw_h < cbm_pkg::H_MIN) ? cbm_pkg::H_MIN : raw_h;
        wait_for_idle();
        data = cbm_pkg::CFG_DATA_W'($urandom);
        write_reg(cbm_pkg::REG_MORPH_MODE, data);
        data = cbm_pkg::CFG_DATA_W'($urandom);
        data[0] = ($urandom_range(3) != 0);
        write_reg(cbm_pkg::REG_APPLY_ENABLE, data);
        data = cbm_pkg::CFG_DATA_W'($urandom);
        data[cbm_pkg::FW_W-1:0] = cbm_pkg::FW_W'(raw_w);
        write_reg(cbm_pkg::REG_FRAME_WIDTH, data);
        write_reg(cbm_pkg::REG_FRAME_HEIGHT, cbm_pkg::CFG_DATA_W'(raw_h));
        frames = $urandom_range(3, 1);
        for (f = 1; f <= frames; f++)
            queue_frame(w, h, f == frames && $urandom_range(4) == 0);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int target);
        int start;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = items_queued;
        while (items_queued - start < target)
            run_random_setting();
        wait_for_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [cbm_pkg::PIX_W-1:0] erode_frame [9];
        logic [cbm_pkg::PIX_W-1:0] dilate_frame [9];
        int k;

        // Erosion: the lone interior pixel has a zero to its right and must
        // clear; the border keeps its gray values.
        erode_frame  = '{8'd255, 8'hAA, 8'd255,
                         8'd255, 8'd255, 8'd0,
                         8'd255, 8'd255, 8'd255};
        // Dilation: the interior pixel sees 255 below it; the border clears.
        dilate_frame = '{8'd0, 8'd0, 8'd0,
                         8'h55, 8'd100, 8'hAA,
                         8'd0, 8'd255, 8'd0};

        wait (rst_n);
        @(posedge clk);

        // Directed part on the smallest frame.
        write_reg(cbm_pkg::REG_FRAME_WIDTH, cbm_pkg::CFG_DATA_W'(3));
        write_reg(cbm_pkg::REG_FRAME_HEIGHT, cbm_pkg::CFG_DATA_W'(3));
        write_reg(cbm_pkg::REG_MORPH_MODE, cbm_pkg::CFG_DATA_W'(cbm_pkg::MODE_ERODE));
        write_reg(cbm_pkg::REG_APPLY_ENABLE, cbm_pkg::CFG_DATA_W'(1));
        for (k = 0; k < 9; k++)
        begin
            // A flush in mid-frame is taken and ignored.
            if (k == 3)
                queue_item(8'hFF, 1'b1);
            queue_item(erode_frame[k], 1'b0);
        end
        // Tail of width + 1; the second entry is a pixel that the block must
        // treat as padding.
        for (k = 0; k < 4; k++)
            queue_item((k == 1) ? 8'd77 : cbm_pkg::PIX_LOW, k != 1);
        wait_for_idle();

        write_reg(cbm_pkg::REG_MORPH_MODE, cbm_pkg::CFG_DATA_W'(cbm_pkg::MODE_DILATE));
        for (k = 0; k < 9; k++)
            queue_item(dilate_frame[k], 1'b0);
        for (k = 0; k < 4; k++)
            queue_item(cbm_pkg::PIX_LOW, 1'b1);
        wait_for_idle();

        // Out-of-range maxima clamp to the largest legal geometry. A line and
        // a little more, so the line stores wrap at the top column and the
        // first results come out. The frame is cut short and the next
        // geometry write restarts it.
        write_reg(cbm_pkg::REG_FRAME_WIDTH, cbm_pkg::CFG_DATA_W'(2047));
        write_reg(cbm_pkg::REG_FRAME_HEIGHT, cbm_pkg::CFG_DATA_W'(8191));
        for (k = 0; k < MAX_W + 6; k++)
            queue_item(random_pixel(30), 1'b0);
        wait_for_idle();

        // Random settings under each idling pattern.
        run_phase(0, 0, 160);
        run_phase(81, 0, 160);
        run_phase(0, 81, 160);
        run_phase(18, 18, 160);

        // Back-pressure: the output is held off for a long stretch while a
        // full frame is offered without gaps, so the block must fill up and
        // stall its input.
        wait_for_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 18;
        write_reg(cbm_pkg::REG_MORPH_MODE, cbm_pkg::CFG_DATA_W'(cbm_pkg::MODE_ERODE));
        write_reg(cbm_pkg::REG_APPLY_ENABLE, cbm_pkg::CFG_DATA_W'(1));
        write_reg(cbm_pkg::REG_FRAME_WIDTH, cbm_pkg::CFG_DATA_W'(12));
        write_reg(cbm_pkg::REG_FRAME_HEIGHT, cbm_pkg::CFG_DATA_W'(8));
        hold_request = 1'b1;
        queue_frame(12, 8, 1'b0);
        wait_for_idle();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
